>>> sv/hhbt_pkg.sv
// Package for the HPACK header block tokenizer.
// Holds the parser phase type, event and representation codes, and the result word type.
// No dependencies.
package hhbt_pkg;

  typedef enum logic [2:0] {
    PH_REP      = 3'd0,
    PH_REP_INT  = 3'd1,
    PH_STR_HDR  = 3'd2,
    PH_STR_INT  = 3'd3,
    PH_STR_BYTE = 3'd4
  } phase_t;

  localparam logic [2:0] EV_REP   = 3'd0;
  localparam logic [2:0] EV_NAME  = 3'd1;
  localparam logic [2:0] EV_VALUE = 3'd2;
  localparam logic [2:0] EV_BYTE  = 3'd3;
  localparam logic [2:0] EV_ERR   = 3'd4;

  localparam logic [2:0] REP_INDEXED = 3'd0;
  localparam logic [2:0] REP_INCR    = 3'd1;
  localparam logic [2:0] REP_WITHOUT = 3'd3;
  localparam logic [2:0] REP_NEVER   = 3'd5;

  localparam logic [5:0] SHIFT_MAX  = 6'd35;
  localparam logic [5:0] SHIFT_STEP = 6'd7;

  typedef struct packed {
    logic        valid;
    logic [2:0]  event_res;
    logic [2:0]  rep_type;
    logic [31:0] field_index;
    logic [31:0] string_length;
    logic        huffman_coded;
    logic [7:0]  string_byte;
    logic        last_of_string;
  } res_t;

endpackage

>>> sv/hhbt_parser.sv
// Parser state and the combinational step logic of the tokenizer.
// Consumes one registered byte per enabled cycle and produces at most one result word.
// Depends on hhbt_pkg.
module hhbt_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [7:0]    data_byte,
  input  logic          first_of_block,
  output hhbt_pkg::res_t res
);
  import hhbt_pkg::*;

  phase_t      phase, phase_b, phase_next;
  logic [31:0] int_accumulator, acc_b, acc_next;
  logic [5:0]  int_shift, shift_b, shift_next;
  logic [2:0]  current_type, type_b, type_next;
  logic [31:0] current_index, index_b, index_next;
  logic [31:0] bytes_remaining, rem_b, rem_next;
  logic        in_name_string, name_b, name_next;
  logic        string_huffman, huf_b, huf_next;
  logic        error_latched, err_b, err_next;

  logic [35:0] acc_sum;
  logic        acc_ovf;
  logic [5:0]  acc_shift;
  logic        rep_done, len_done, str_done, raise_err;
  logic [2:0]  rep_base;
  logic [31:0] rep_idx, len_val;
  logic        last_byte;

  always_comb begin
    if (first_of_block) begin
      phase_b = PH_REP;
      acc_b   = '0;
      shift_b = '0;
      type_b  = '0;
      index_b = '0;
      rem_b   = '0;
      name_b  = 1'b0;
      huf_b   = 1'b0;
      err_b   = 1'b0;
    end else begin
      phase_b = phase;
      acc_b   = int_accumulator;
      shift_b = int_shift;
      type_b  = current_type;
      index_b = current_index;
      rem_b   = bytes_remaining;
      name_b  = in_name_string;
      huf_b   = string_huffman;
      err_b   = error_latched;
    end
  end

  always_comb begin
    acc_sum   = {4'b0, acc_b} + ({29'b0, data_byte[6:0]} << shift_b);
    acc_shift = (shift_b >= (SHIFT_MAX - SHIFT_STEP)) ? SHIFT_MAX : shift_b + SHIFT_STEP;
    if (shift_b >= 6'd32) begin
      acc_ovf = |data_byte[6:0];
    end else begin
      acc_ovf = |acc_sum[35:32];
    end
  end

  always_comb begin
    phase_next = phase_b;
    acc_next   = acc_b;
    shift_next = shift_b;
    type_next  = type_b;
    index_next = index_b;
    rem_next   = rem_b;
    name_next  = name_b;
    huf_next   = huf_b;
    err_next   = err_b;
    res        = '0;
    rep_done   = 1'b0;
    rep_base   = REP_INDEXED;
    rep_idx    = '0;
    len_done   = 1'b0;
    len_val    = '0;
    str_done   = 1'b0;
    raise_err  = 1'b0;
    last_byte  = (rem_b <= 32'd1);

    if (en && !err_b) begin
      unique case (phase_b)
        PH_REP: begin
          priority if (data_byte[7]) begin
            rep_base = REP_INDEXED;
            rep_idx  = {25'b0, data_byte[6:0]};
            rep_done = ~&data_byte[6:0];
            acc_next = 32'h7F;
          end else if (data_byte[6]) begin
            rep_base = REP_INCR;
            rep_idx  = {26'b0, data_byte[5:0]};
            rep_done = ~&data_byte[5:0];
            acc_next = 32'h3F;
          end else if (data_byte[7:4] == 4'd0) begin
            rep_base = REP_WITHOUT;
            rep_idx  = {28'b0, data_byte[3:0]};
            rep_done = ~&data_byte[3:0];
            acc_next = 32'h0F;
          end else if (data_byte[4]) begin
            rep_base = REP_NEVER;
            rep_idx  = {28'b0, data_byte[3:0]};
            rep_done = ~&data_byte[3:0];
            acc_next = 32'h0F;
          end else begin
            raise_err = 1'b1;
            acc_next  = acc_b;
          end
          if (!raise_err) begin
            type_next = rep_base;
            if (!rep_done) begin
              shift_next = '0;
              phase_next = PH_REP_INT;
            end
          end
        end
        PH_REP_INT: begin
          if (acc_ovf) begin
            raise_err = 1'b1;
          end else begin
            acc_next   = acc_sum[31:0];
            shift_next = acc_shift;
            rep_base   = type_b;
            rep_idx    = acc_sum[31:0];
            rep_done   = !data_byte[7];
          end
        end
        PH_STR_HDR: begin
          huf_next = data_byte[7];
          if (~&data_byte[6:0]) begin
            len_done = 1'b1;
            len_val  = {25'b0, data_byte[6:0]};
          end else begin
            acc_next   = 32'h7F;
            shift_next = '0;
            phase_next = PH_STR_INT;
          end
        end
        PH_STR_INT: begin
          if (acc_ovf) begin
            raise_err = 1'b1;
          end else begin
            acc_next   = acc_sum[31:0];
            shift_next = acc_shift;
            len_val    = acc_sum[31:0];
            len_done   = !data_byte[7];
          end
        end
        PH_STR_BYTE: begin
          res.valid          = 1'b1;
          res.event_res      = EV_BYTE;
          res.rep_type       = type_b;
          res.field_index    = index_b;
          res.huffman_coded  = huf_b;
          res.string_byte    = data_byte;
          res.last_of_string = last_byte;
          if (last_byte) begin
            rem_next = '0;
            str_done = 1'b1;
          end else begin
            rem_next = rem_b - 32'd1;
          end
        end
        default: begin
          phase_next = PH_REP;
        end
      endcase

      if (raise_err) begin
        err_next   = 1'b1;
        phase_next = PH_REP;
        res        = '0;
        res.valid  = 1'b1;
        res.event_res = EV_ERR;
      end

      if (rep_done) begin
        index_next = rep_idx;
        if (rep_base == REP_INDEXED) begin
          type_next  = REP_INDEXED;
          phase_next = PH_REP;
        end else begin
          type_next  = (rep_idx == 32'd0) ? rep_base + 3'd1 : rep_base;
          name_next  = (rep_idx == 32'd0);
          phase_next = PH_STR_HDR;
        end
        res.valid       = 1'b1;
        res.event_res   = EV_REP;
        res.rep_type    = type_next;
        res.field_index = rep_idx;
      end

      if (len_done) begin
        res.valid         = 1'b1;
        res.event_res     = name_b ? EV_NAME : EV_VALUE;
        res.rep_type      = type_b;
        res.field_index   = index_b;
        res.string_length = len_val;
        res.huffman_coded = huf_next;
        rem_next          = len_val;
        if (len_val == 32'd0) begin
          str_done = 1'b1;
        end else begin
          phase_next = PH_STR_BYTE;
        end
      end

      if (str_done) begin
        if (name_b) begin
          name_next  = 1'b0;
          phase_next = PH_STR_HDR;
        end else begin
          phase_next = PH_REP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_REP;
      int_accumulator <= '0;
      int_shift       <= '0;
      current_type    <= '0;
      current_index   <= '0;
      bytes_remaining <= '0;
      in_name_string  <= 1'b0;
      string_huffman  <= 1'b0;
      error_latched   <= 1'b0;
    end else if (en) begin
      phase           <= phase_next;
      int_accumulator <= acc_next;
      int_shift       <= shift_next;
      current_type    <= type_next;
      current_index   <= index_next;
      bytes_remaining <= rem_next;
      in_name_string  <= name_next;
      string_huffman  <= huf_next;
      error_latched   <= err_next;
    end
  end

  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    (en && error_latched && !first_of_block) |-> !res.valid)
    else $error("Result produced while an error is held.");

  a_bytes_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STR_BYTE) |-> (bytes_remaining != 32'd0))
    else $error("String byte phase with no bytes remaining.");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    int_shift <= SHIFT_MAX)
    else $error("Integer shift out of range.");

endmodule

>>> sv/hpack_header_block_tokenizer_unit.sv
// Top level of the HPACK header block tokenizer.
// A byte's word goes from the input register through the parser step into the result register.
// Throughput: one byte per cycle while no held result word stalls the input.
// The only stall comes from the output side holding a result word.
// Reset (rst, synchronous) empties both registers and returns the parser to its block start.
// Depends on hhbt_pkg and hhbt_parser.
module hpack_header_block_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [2:0]  rep_type,
  output logic [31:0] field_index,
  output logic [31:0] string_length,
  output logic        huffman_coded,
  output logic [7:0]  string_byte,
  output logic        last_of_string
);
  import hhbt_pkg::*;

  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_first;
  logic       advance;
  logic       out_free;
  res_t       res;
  res_t       out_word;

  assign out_free = !out_valid || !out_stall;
  assign advance  = ir_valid && out_free;
  assign in_stall = ir_valid && !out_free;

  hhbt_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .data_byte      (ir_byte),
    .first_of_block (ir_first),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      ir_byte  <= data_byte;
      ir_first <= first_of_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_word <= res;
    end
  end

  assign event_res      = out_word.event_res;
  assign rep_type       = out_word.rep_type;
  assign field_index    = out_word.field_index;
  assign string_length  = out_word.string_length;
  assign huffman_coded  = out_word.huffman_coded;
  assign string_byte    = out_word.string_byte;
  assign last_of_string = out_word.last_of_string;

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (ir_valid && out_valid && out_stall))
    else $error("Input stalled without a held result word.");

  a_word_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && res.valid) |=> out_valid)
    else $error("Parser result word was dropped.");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !advance) |=> !out_valid)
    else $error("Result word appeared without a parsed byte.");

endmodule

>>> tb/sv/hpack_header_block_tokenizer_unit_test.sv
// Testbench for hpack_header_block_tokenizer_unit: feeds HPACK header blocks byte by byte
// and checks every result word against a cycle-free prediction of the tokenizer.
// Depends on hhbt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module hpack_header_block_tokenizer_unit_test;
  import hhbt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  rep;
    logic [31:0] index;
    logic [31:0] length;
    logic        huffman;
    logic [7:0]  data;
    logic        last_flag;
  } token_t;

  typedef struct {
    logic [7:0] data;
    logic       starts_block;
    logic       hold_for_drain;
  } block_byte_t;

  typedef enum logic [1:0] {FORM_INDEXED, FORM_INCR, FORM_WITHOUT, FORM_NEVER} rep_form_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        first_of_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [2:0]  rep_type;
  logic [31:0] field_index;
  logic [31:0] string_length;
  logic        huffman_coded;
  logic [7:0]  string_byte;
  logic        last_of_string;

  block_byte_t byte_queue[$];
  token_t      expected_tokens[$];
  logic        byte_taken = 1'b0;
  int unsigned send_idle_pct = 35;
  int unsigned recv_stall_pct = 65;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_queued = 0;
  logic        new_block = 1'b0;
  logic        hold_for_drain = 1'b0;

  phase_t      parse_phase;
  logic [32:0] int_acc;
  logic [5:0]  int_shift;
  logic [2:0]  cur_type;
  logic [31:0] cur_index;
  logic [31:0] bytes_left;
  logic        in_name;
  logic        str_huff;
  logic        err_held;

  hpack_header_block_tokenizer_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_parser();
    parse_phase = PH_REP;
    int_acc = '0;
    int_shift = '0;
    cur_type = '0;
    cur_index = '0;
    bytes_left = '0;
    in_name = 1'b0;
    str_huff = 1'b0;
    err_held = 1'b0;
  endfunction

  function automatic void push_token(input logic [2:0] kind, input logic [31:0] length,
                                     input logic [7:0] data, input logic last_flag);
    token_t t;
    t.kind      = kind;
    t.rep       = cur_type;
    t.index     = cur_index;
    t.length    = length;
    t.huffman   = (kind == EV_REP) ? 1'b0 : str_huff;
    t.data      = data;
    t.last_flag = last_flag;
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void flag_error();
    token_t t;
    err_held = 1'b1;
    parse_phase = PH_REP;
    t = '0;
    t.kind = EV_ERR;
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void string_done();
    if (in_name) begin
      in_name = 1'b0;
      parse_phase = PH_STR_HDR;
    end else begin
      parse_phase = PH_REP;
    end
  endfunction

  function automatic void finish_rep(input logic [2:0] base, input logic [31:0] idx);
    cur_index = idx;
    if (base == REP_INDEXED) begin
      cur_type = REP_INDEXED;
      parse_phase = PH_REP;
    end else begin
      cur_type = (idx == 0) ? base + 3'd1 : base;
      in_name = (idx == 0);
      parse_phase = PH_STR_HDR;
    end
    push_token(EV_REP, 32'd0, 8'd0, 1'b0);
  endfunction

  function automatic void finish_len(input logic [31:0] len);
    push_token(in_name ? EV_NAME : EV_VALUE, len, 8'd0, 1'b0);
    bytes_left = len;
    if (len == 0) string_done();
    else parse_phase = PH_STR_BYTE;
  endfunction

  function automatic logic int_overflows(input logic [7:0] b);
    logic [63:0] sum;
    if (int_shift >= 6'd32) begin
      if (b[6:0] != 7'd0) return 1'b1;
    end else begin
      sum = 64'(int_acc) + (64'(b[6:0]) << int_shift);
      if (sum > 64'hFFFF_FFFF) return 1'b1;
      int_acc = sum[32:0];
    end
    int_shift = (int_shift + SHIFT_STEP > SHIFT_MAX) ? SHIFT_MAX : int_shift + SHIFT_STEP;
    return 1'b0;
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic starts_block);
    logic [2:0] base;
    logic [7:0] mask;
    logic       is_last;
    if (starts_block) clear_parser();
    if (err_held) return;
    case (parse_phase)
      PH_REP: begin
        if (b[7]) begin
          base = REP_INDEXED;
          mask = 8'h7F;
        end else if (b[6]) begin
          base = REP_INCR;
          mask = 8'h3F;
        end else if (b[7:4] == 4'h0) begin
          base = REP_WITHOUT;
          mask = 8'h0F;
        end else if (b[4]) begin
          base = REP_NEVER;
          mask = 8'h0F;
        end else begin
          flag_error();
          return;
        end
        cur_type = base;
        if ((b & mask) < mask) begin
          finish_rep(base, 32'(b & mask));
        end else begin
          int_acc = 33'(mask);
          int_shift = '0;
          parse_phase = PH_REP_INT;
        end
      end
      PH_REP_INT: begin
        if (int_overflows(b)) flag_error();
        else if (!b[7]) finish_rep(cur_type, int_acc[31:0]);
      end
      PH_STR_HDR: begin
        str_huff = b[7];
        if (b[6:0] != 7'h7F) begin
          finish_len(32'(b[6:0]));
        end else begin
          int_acc = 33'h7F;
          int_shift = '0;
          parse_phase = PH_STR_INT;
        end
      end
      PH_STR_INT: begin
        if (int_overflows(b)) flag_error();
        else if (!b[7]) finish_len(int_acc[31:0]);
      end
      PH_STR_BYTE: begin
        is_last = (bytes_left <= 1);
        push_token(EV_BYTE, 32'd0, b, is_last);
        if (is_last) begin
          bytes_left = '0;
          string_done();
        end else begin
          bytes_left = bytes_left - 1;
        end
      end
      default: parse_phase = PH_REP;
    endcase
  endfunction

  function automatic string token_text(input token_t t);
    return $sformatf("event %0d type %0d index %0d length %0d huffman %0b byte %02h last %0b",
                     t.kind, t.rep, t.index, t.length, t.huffman, t.data, t.last_flag);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!in_valid || byte_taken) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(byte_queue[0].hold_for_drain && expected_tokens.size() != 0)) begin
          in_valid <= 1'b1;
          data_byte <= byte_queue[0].data;
          first_of_block <= byte_queue[0].starts_block;
          void'(byte_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    token_t got;
    token_t want;
    if (rst) begin
      byte_taken <= 1'b0;
      clear_parser();
    end else begin
      byte_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) tokenize_byte(data_byte, first_of_block);
      if (out_valid && !out_stall) begin
        got = '{event_res, rep_type, field_index, string_length, huffman_coded,
                string_byte, last_of_string};
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected word: %s", token_text(got));
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch: expected %s", token_text(want));
              $display("          actual   %s", token_text(got));
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    block_byte_t entry;
    entry.data = b;
    entry.starts_block = new_block;
    entry.hold_for_drain = hold_for_drain;
    byte_queue.insert(byte_queue.size(), entry);
    new_block = 1'b0;
    hold_for_drain = 1'b0;
    bytes_queued++;
  endtask

  task automatic push_int(input logic [7:0] top, input int unsigned width,
                          input logic [63:0] value, input int unsigned pad);
    logic [7:0]  mask;
    logic [63:0] rest;
    mask = 8'((1 << width) - 1);
    if (value < 64'(mask)) begin
      push_byte(top | value[7:0]);
      return;
    end
    push_byte(top | mask);
    rest = value - 64'(mask);
    while (rest >= 128) begin
      push_byte({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    if (pad == 0) begin
      push_byte(rest[7:0]);
    end else begin
      push_byte({1'b1, rest[6:0]});
      repeat (pad - 1) push_byte(8'h80);
      push_byte(8'h00);
    end
  endtask

  function automatic logic [63:0] random_int();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return 64'd0;
    if (sel < 55) return 64'($urandom_range(1, 20));
    if (sel < 70) return 64'($urandom_range(0, 200));
    if (sel < 80) return 64'($urandom_range(0, 1 << 16));
    if (sel < 88) return {32'd0, $urandom};
    if (sel < 94) return 64'hFFFF_FFFF;
    return {24'd0, 8'($urandom_range(1, 255)), $urandom};
  endfunction

  function automatic int unsigned random_pad();
    return ($urandom_range(19) == 0) ? $urandom_range(1, 6) : 0;
  endfunction

  task automatic random_string(output logic cut);
    logic        huff;
    logic [63:0] len;
    int unsigned sel;
    int unsigned send;
    huff = 1'($urandom_range(1));
    sel = $urandom_range(199);
    cut = 1'b0;
    if (sel < 10) len = random_int();
    else if (sel < 13) len = 64'($urandom_range(126, 127));
    else len = 64'($urandom_range(0, 8));
    push_int({huff, 7'd0}, 7, len, random_pad());
    if (len > 64'hFFFF_FFFF) begin
      cut = 1'b1;
      return;
    end
    if (len > 130) begin
      send = $urandom_range(0, 6);
      cut = 1'b1;
    end else begin
      send = int'(len);
    end
    repeat (send) push_byte(8'($urandom_range(255)));
  endtask

  task automatic random_rep(output logic cut);
    rep_form_t   form;
    logic [63:0] idx;
    form = rep_form_t'($urandom_range(3));
    idx = random_int();
    cut = 1'b0;
    case (form)
      FORM_INDEXED: push_int(8'h80, 7, idx, random_pad());
      FORM_INCR:    push_int(8'h40, 6, idx, random_pad());
      FORM_WITHOUT: push_int(8'h00, 4, idx, random_pad());
      default:      push_int(8'h10, 4, idx, random_pad());
    endcase
    if (idx > 64'hFFFF_FFFF) begin
      cut = 1'b1;
      return;
    end
    if (form == FORM_INDEXED) return;
    if (idx == 0) begin
      random_string(cut);
      if (cut) return;
    end
    random_string(cut);
  endtask

  task automatic random_block();
    int unsigned sel;
    logic        cut;
    new_block = 1'b1;
    sel = $urandom_range(99);
    if (sel < 6) begin
      push_byte(8'h20 | 8'($urandom_range(31)));
      repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)));
    end else if (sel < 12) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        random_rep(cut);
        if (cut) break;
      end
    end
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) begin
      if ($urandom_range(9) == 0) hold_for_drain = 1'b1;
      random_block();
    end
    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    new_block = 1'b1;
    push_byte(8'h82);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h81);
    push_byte(8'hFF);
    push_byte(8'h7F);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'h10);
    push_byte(8'h01);
    push_byte(8'hAA);
    push_byte(8'h00);
    new_block = 1'b1;
    push_int(8'h80, 7, 64'hFFFF_FFFF, 0);
    new_block = 1'b1;
    push_byte(8'h20);
    push_byte(8'h80);
    new_block = 1'b1;
    push_byte(8'h40);
    push_byte(8'hFF);
    new_block = 1'b1;
    hold_for_drain = 1'b1;
    push_byte(8'h85);

    random_phase(120);
    send_idle_pct = 65;
    recv_stall_pct = 35;
    random_phase(120);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(120);

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
